>>> rtl/core/appe_pkg.sv
// Package for the azimuth peak pan estimator.
// Holds the shared widths, register codes, reset values and the back-end state type.
// No dependencies; every other file of the block depends on it.
package appe_pkg;

	localparam int MAX_HALF_WIDTH_DEF = 255;
	localparam int MAX_BINS_DEF       = 4096;
	localparam int MAG_BITS_DEF       = 16;

	localparam int HW_REG_W   = 8;
	localparam int BINS_REG_W = 13;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 13;

	localparam logic [HW_REG_W-1:0]   HW_RESET   = 8'd100;
	localparam logic [BINS_REG_W-1:0] BINS_RESET = 13'd512;

	localparam logic [CFG_IDX_W-1:0] REG_HALF_WIDTH    = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_BINS_IN_FRAME = 1'b1;

	localparam int PAN_W      = 16;
	localparam int PAN_FRAC   = 14;
	localparam int PIDX_W     = 9;
	localparam int BIN_W      = 12;
	localparam int WIDE_IDX_W = 32;
	localparam int QUEUE_DEPTH = 4;

	localparam logic [PAN_W-1:0] PAN_ONE = 16'd16384;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_RUN,
		BK_DONE
	} bk_state_t;

endpackage

>>> rtl/core/appe_mag_if.sv
// Input channel of the azimuth peak pan estimator: one azimuth position per item.
// Depends on appe_pkg for the default magnitude width.
interface appe_mag_if #(
	parameter int MAG_BITS = appe_pkg::MAG_BITS_DEF
) ();
	logic                valid;
	logic                ready;
	logic [MAG_BITS-1:0] left_mag;
	logic [MAG_BITS-1:0] right_mag;

	modport source (output valid, output left_mag, output right_mag, input ready);
	modport sink (input valid, input left_mag, input right_mag, output ready);
endinterface

>>> rtl/core/appe_pan_if.sv
// Result channel of the azimuth peak pan estimator: one pan estimate per bin.
// Depends on appe_pkg for the field widths.
interface appe_pan_if ();
	logic                                    valid;
	logic                                    ready;
	logic signed [appe_pkg::PAN_W-1:0]       pan_value;
	logic        [appe_pkg::PIDX_W-1:0]      pan_index;
	logic        [appe_pkg::BIN_W-1:0]       bin_number;
	logic                                    frame_last;

	modport source (output valid, output pan_value, output pan_index, output bin_number,
		output frame_last, input ready);
	modport sink (input valid, input pan_value, input pan_index, input bin_number,
		input frame_last, output ready);
endinterface

>>> rtl/core/appe_front.sv
// Front end: running left/right peak search over the positions of one bin.
// Emits one record per bin (merged index, half width, bin number, last flag).
// Depends on appe_pkg and appe_mag_if.
module appe_front #(
	parameter int MAG_BITS       = appe_pkg::MAG_BITS_DEF,
	parameter int MAX_HALF_WIDTH = appe_pkg::MAX_HALF_WIDTH_DEF,
	parameter int MAX_BINS       = appe_pkg::MAX_BINS_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic [$clog2(MAX_HALF_WIDTH+1)-1:0]    hw,
	input  logic [$clog2(MAX_BINS+1)-1:0]          nb,
	appe_mag_if.sink                               mag,
	output logic                                   rec_valid,
	input  logic                                   rec_ready,
	output logic [$clog2(2*MAX_HALF_WIDTH+2)+$clog2(MAX_HALF_WIDTH+1)+appe_pkg::BIN_W+1:0]
	                                               rec_data
);
	import appe_pkg::*;

	localparam int HW_W  = $clog2(MAX_HALF_WIDTH+1);
	localparam int IDX_W = $clog2(2*MAX_HALF_WIDTH+2);
	localparam int IS_W  = IDX_W + 1;

	logic [HW_W-1:0]        pos_q;
	logic [BIN_W-1:0]       bin_q;
	logic [MAG_BITS-1:0]    best_mag_q;
	logic signed [IS_W-1:0] best_idx_q;

	logic                   start;
	logic                   at_end;
	logic                   last;
	logic                   accept;
	logic signed [IS_W-1:0] hw_s;
	logic signed [IS_W-1:0] t_s;
	logic [MAG_BITS-1:0]    nxt_mag;
	logic signed [IS_W-1:0] nxt_idx;
	logic signed [IS_W-1:0] fin_idx;

	always_comb begin
		start   = (pos_q == '0);
		hw_s    = IS_W'(hw);
		t_s     = IS_W'(pos_q);
		nxt_mag = start ? '0 : best_mag_q;
		nxt_idx = start ? hw_s : best_idx_q;
		if (mag.left_mag > nxt_mag) begin
			nxt_mag = mag.left_mag;
			nxt_idx = t_s;
		end
		// The right side is checked after the left, so it wins only when strictly larger.
		if (mag.right_mag > nxt_mag) begin
			nxt_mag = mag.right_mag;
			nxt_idx = (hw_s <<< 1) + IS_W'(1) - t_s;
		end
		// A negative index (half width lowered mid-bin) counts as above the center too.
		if (nxt_idx[IS_W-1] || (nxt_idx > hw_s)) begin
			fin_idx = nxt_idx - IS_W'(1);
		end else begin
			fin_idx = nxt_idx;
		end
		at_end = (pos_q >= hw);
		last   = ((32'(bin_q) + 32'd1) >= 32'(nb));
	end

	assign mag.ready = !at_end || rec_ready;
	assign accept    = mag.valid && mag.ready;
	assign rec_valid = mag.valid && at_end;
	assign rec_data  = {fin_idx, hw, bin_q, last};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			bin_q <= '0;
		end else if (accept) begin
			if (at_end) begin
				pos_q <= '0;
				bin_q <= last ? '0 : BIN_W'(bin_q + 1'b1);
			end else begin
				pos_q <= HW_W'(pos_q + 1'b1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			best_mag_q <= nxt_mag;
			best_idx_q <= nxt_idx;
		end
	end

endmodule

>>> rtl/core/appe_queue.sv
// Short FIFO that decouples the peak search from the pan divider.
// Depends on appe_pkg for the default depth; width and depth are parameters.
module appe_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = appe_pkg::QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push_valid,
	output logic             push_ready,
	input  logic [WIDTH-1:0] push_data,
	output logic             pop_valid,
	input  logic             pop_ready,
	output logic [WIDTH-1:0] pop_data
);
	import appe_pkg::*;

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH+1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             push;
	logic             pop;

	assign push_ready = (cnt_q != CNT_W'(DEPTH));
	assign pop_valid  = (cnt_q != '0);
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_data   = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH-1)) ? '0 : PTR_W'(wr_ptr_q + 1'b1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH-1)) ? '0 : PTR_W'(rd_ptr_q + 1'b1);
			end
			if (push && !pop) begin
				cnt_q <= CNT_W'(cnt_q + 1'b1);
			end else if (pop && !push) begin
				cnt_q <= CNT_W'(cnt_q - 1'b1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

`ifndef SYNTHESIS
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(DEPTH))
		else $error("queue count exceeds depth");
	a_cnt_up: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> (cnt_q == CNT_W'($past(cnt_q) + 1'b1)))
		else $error("queue count did not follow a push");
	a_empty_ptrs: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == '0) |-> (rd_ptr_q == wr_ptr_q))
		else $error("empty queue with unequal pointers");
`endif

endmodule

>>> rtl/core/appe_back.sv
// Back end: restoring divider for index*16384/half_width, one quotient bit per cycle,
// followed by the output register of the result channel.
// Depends on appe_pkg and appe_pan_if.
module appe_back #(
	parameter int MAX_HALF_WIDTH = appe_pkg::MAX_HALF_WIDTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                rec_valid,
	output logic                                rec_ready,
	input  logic [$clog2(2*MAX_HALF_WIDTH+2)+$clog2(MAX_HALF_WIDTH+1)+appe_pkg::BIN_W+1:0]
	                                            rec_data,
	appe_pan_if.source                          pan
);
	import appe_pkg::*;

	localparam int HW_W   = $clog2(MAX_HALF_WIDTH+1);
	localparam int IDX_W  = $clog2(2*MAX_HALF_WIDTH+2);
	localparam int IS_W   = IDX_W + 1;
	localparam int REC_W  = IS_W + HW_W + BIN_W + 1;
	localparam int DIV_W  = WIDE_IDX_W + PAN_FRAC;
	localparam int SKIP   = WIDE_IDX_W - IDX_W;
	localparam int STEP_W = $clog2(DIV_W+1);

	bk_state_t state_q, state_d;

	logic signed [IS_W-1:0] rec_idx;
	logic [HW_W-1:0]        rec_hw;
	logic [BIN_W-1:0]       rec_bin;
	logic                   rec_last;
	logic [WIDE_IDX_W-1:0]  wide_idx;
	logic [DIV_W-1:0]       full_dvd;
	logic [DIV_W-1:0]       load_dvd;
	logic [STEP_W-1:0]      load_steps;

	logic [DIV_W-1:0]  dvd_q;
	logic [HW_W-1:0]   rem_q;
	logic [HW_W-1:0]   dvs_q;
	logic [PAN_W-1:0]  quo_q;
	logic [STEP_W-1:0] step_q;
	logic [PIDX_W-1:0] pidx_q;
	logic [BIN_W-1:0]  bin_q;
	logic              last_q;

	logic              out_valid_q;
	logic [PAN_W-1:0]  out_pan_q;
	logic [PIDX_W-1:0] out_pidx_q;
	logic [BIN_W-1:0]  out_bin_q;
	logic              out_last_q;

	logic              slot_free;
	logic              load;
	logic              step;
	logic              out_load;
	logic [HW_W:0]     trial;
	logic              ge;
	logic [HW_W-1:0]   rem_n;

	assign rec_idx  = rec_data[REC_W-1 -: IS_W];
	assign rec_hw   = rec_data[BIN_W+1 +: HW_W];
	assign rec_bin  = rec_data[1 +: BIN_W];
	assign rec_last = rec_data[0];

	// The index is sign-extended to 32 bits, so a negative index divides as a huge value.
	// For a non-negative index the leading zero bits are skipped.
	always_comb begin
		wide_idx = WIDE_IDX_W'(rec_idx);
		full_dvd = {wide_idx, PAN_FRAC'(0)};
		if (rec_idx[IS_W-1]) begin
			load_dvd   = full_dvd;
			load_steps = STEP_W'(DIV_W);
		end else begin
			load_dvd   = full_dvd << SKIP;
			load_steps = STEP_W'(IDX_W + PAN_FRAC);
		end
	end

	always_comb begin
		trial = {rem_q, dvd_q[DIV_W-1]};
		ge    = (trial >= {1'b0, dvs_q});
		rem_n = ge ? HW_W'(trial - {1'b0, dvs_q}) : trial[HW_W-1:0];
	end

	assign slot_free = !out_valid_q || pan.ready;

	always_comb begin
		state_d   = state_q;
		rec_ready = 1'b0;
		load      = 1'b0;
		step      = 1'b0;
		out_load  = 1'b0;
		unique case (state_q)
			BK_IDLE: begin
				if (rec_valid) begin
					rec_ready = 1'b1;
					load      = 1'b1;
					state_d   = BK_RUN;
				end
			end
			BK_RUN: begin
				step = 1'b1;
				if (step_q == STEP_W'(1)) begin
					state_d = BK_DONE;
				end
			end
			BK_DONE: begin
				if (slot_free) begin
					out_load = 1'b1;
					if (rec_valid) begin
						rec_ready = 1'b1;
						load      = 1'b1;
						state_d   = BK_RUN;
					end else begin
						state_d = BK_IDLE;
					end
				end
			end
			default: begin
				state_d = BK_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load) begin
				step_q <= load_steps;
			end else if (step) begin
				step_q <= STEP_W'(step_q - 1'b1);
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (pan.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			dvd_q  <= load_dvd;
			rem_q  <= '0;
			quo_q  <= '0;
			dvs_q  <= rec_hw;
			pidx_q <= wide_idx[PIDX_W-1:0];
			bin_q  <= rec_bin;
			last_q <= rec_last;
		end else if (step) begin
			dvd_q <= dvd_q << 1;
			rem_q <= rem_n;
			quo_q <= {quo_q[PAN_W-2:0], ge};
		end
		if (out_load) begin
			out_pan_q  <= quo_q - PAN_ONE;
			out_pidx_q <= pidx_q;
			out_bin_q  <= bin_q;
			out_last_q <= last_q;
		end
	end

	assign pan.valid      = out_valid_q;
	assign pan.pan_value  = out_pan_q;
	assign pan.pan_index  = out_pidx_q;
	assign pan.bin_number = out_bin_q;
	assign pan.frame_last = out_last_q;

`ifndef SYNTHESIS
	a_rem_below_dvs: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == BK_RUN) |-> ((dvs_q != '0) && (rem_q < dvs_q)))
		else $error("divider remainder not below divisor");
	a_steps_left: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == BK_RUN) |-> (step_q != '0))
		else $error("divider running with no steps left");
	a_out_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(state_q) == BK_DONE))
		else $error("result shown without a finished division");
`endif

endmodule

>>> rtl/core/azimuth_peak_pan_estimator_top.sv
// Azimuth peak pan estimator: one azimuth position per item, one pan result per bin.
// Throughput: one item per cycle, except that the last item of a bin waits while the
// record queue is full; the bit-serial divider works on one result at a time.
// A four-entry record queue lets the search run ahead of the divider.
// Reset (arst_n, asynchronous, active low) restores the registers and empties everything.
module azimuth_peak_pan_estimator_top #(
	parameter int MAX_HALF_WIDTH = appe_pkg::MAX_HALF_WIDTH_DEF,
	parameter int MAX_BINS       = appe_pkg::MAX_BINS_DEF,
	parameter int MAG_BITS       = appe_pkg::MAG_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	appe_mag_if.sink                         mag,
	appe_pan_if.source                       pan,
	input  logic                             cfg_we,
	input  logic [appe_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [appe_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import appe_pkg::*;

	localparam int HW_W  = $clog2(MAX_HALF_WIDTH+1);
	localparam int IDX_W = $clog2(2*MAX_HALF_WIDTH+2);
	localparam int NB_W  = $clog2(MAX_BINS+1);
	localparam int REC_W = IDX_W + 1 + HW_W + BIN_W + 1;

	logic [HW_REG_W-1:0]   hw_reg_q;
	logic [BINS_REG_W-1:0] bins_reg_q;
	logic [HW_W-1:0]       hw_eff;
	logic [NB_W-1:0]       nb_eff;

	logic             f_valid;
	logic             f_ready;
	logic [REC_W-1:0] f_data;
	logic             b_valid;
	logic             b_ready;
	logic [REC_W-1:0] b_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hw_reg_q   <= HW_RESET;
			bins_reg_q <= BINS_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_HALF_WIDTH:    hw_reg_q   <= cfg_data[HW_REG_W-1:0];
				REG_BINS_IN_FRAME: bins_reg_q <= cfg_data[BINS_REG_W-1:0];
			endcase
		end
	end

	// Zero settings act as one; oversized settings are clamped to the build limits.
	always_comb begin
		priority if (hw_reg_q == '0) begin
			hw_eff = HW_W'(1);
		end else if (32'(hw_reg_q) > 32'(MAX_HALF_WIDTH)) begin
			hw_eff = HW_W'(MAX_HALF_WIDTH);
		end else begin
			hw_eff = HW_W'(hw_reg_q);
		end
		priority if (bins_reg_q == '0) begin
			nb_eff = NB_W'(1);
		end else if (32'(bins_reg_q) > 32'(MAX_BINS)) begin
			nb_eff = NB_W'(MAX_BINS);
		end else begin
			nb_eff = NB_W'(bins_reg_q);
		end
	end

	appe_front #(
		.MAG_BITS      (MAG_BITS),
		.MAX_HALF_WIDTH(MAX_HALF_WIDTH),
		.MAX_BINS      (MAX_BINS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.hw       (hw_eff),
		.nb       (nb_eff),
		.mag      (mag),
		.rec_valid(f_valid),
		.rec_ready(f_ready),
		.rec_data (f_data)
	);

	appe_queue #(
		.WIDTH(REC_W),
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_valid(f_valid),
		.push_ready(f_ready),
		.push_data (f_data),
		.pop_valid (b_valid),
		.pop_ready (b_ready),
		.pop_data  (b_data)
	);

	appe_back #(
		.MAX_HALF_WIDTH(MAX_HALF_WIDTH)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.rec_valid(b_valid),
		.rec_ready(b_ready),
		.rec_data (b_data),
		.pan      (pan)
	);

endmodule

>>> dv/azimuth_peak_pan_estimator_top_test.sv
// Self-checking testbench for azimuth_peak_pan_estimator_top.
// Streams azimuth positions with random gaps, predicts each bin's pan result and checks it.
// Depends on appe_pkg, appe_mag_if and appe_pan_if from the RTL.
`timescale 1ns / 100ps

module azimuth_peak_pan_estimator_top_test;
	import appe_pkg::*;

	localparam int ITEM_TARGET = 1200;
	localparam int DRAIN_CYCLES = 64;

	typedef struct packed {
		logic [MAG_BITS_DEF-1:0] left_mag;
		logic [MAG_BITS_DEF-1:0] right_mag;
	} mag_pair_t;

	typedef struct packed {
		logic signed [PAN_W-1:0] pan_value;
		logic [PIDX_W-1:0]       pan_index;
		logic [BIN_W-1:0]        bin_number;
		logic                    frame_last;
	} pan_result_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	appe_mag_if #(.MAG_BITS(MAG_BITS_DEF)) mag_ch ();
	appe_pan_if pan_ch ();

	azimuth_peak_pan_estimator_top u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.mag(mag_ch),
		.pan(pan_ch),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// Predicted block state and register copies.
	logic [HW_REG_W-1:0]     hw_setting;
	logic [BINS_REG_W-1:0]   bins_setting;
	logic [MAG_BITS_DEF-1:0] peak_mag;
	int unsigned             peak_index;
	int unsigned             position;
	int unsigned             bin_count;

	mag_pair_t   positions_to_send[$];
	pan_result_t pans_due[$];

	int items_queued = 0;
	int items_accepted = 0;
	int results_checked = 0;
	int frames_closed = 0;
	int registers_written = 0;
	int mismatches = 0;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("Mismatches found");
		$finish;
	end

	function automatic int unsigned active_half_width();
		return (hw_setting == 0) ? 1 : hw_setting;
	endfunction

	function automatic void predict_pan(input mag_pair_t item);
		int unsigned       hw;
		int unsigned       idx;
		int unsigned       frame_bins;
		longint unsigned   scaled;
		pan_result_t       res;
		hw = active_half_width();
		if (position == 0) begin
			peak_mag = '0;
			peak_index = hw;
		end
		if (item.left_mag > peak_mag) begin
			peak_mag = item.left_mag;
			peak_index = position;
		end
		// The right side counts down from the far end; it may wrap if the width shrank mid-bin.
		if (item.right_mag > peak_mag) begin
			peak_mag = item.right_mag;
			peak_index = 2 * hw + 1 - position;
		end
		if (position < hw) begin
			position++;
		end else begin
			idx = peak_index;
			if (idx > hw)
				idx--;
			scaled = idx;
			scaled = (scaled * PAN_ONE) / hw;
			res.pan_value = PAN_W'(scaled - PAN_ONE);
			res.pan_index = idx[PIDX_W-1:0];
			res.bin_number = bin_count[BIN_W-1:0];
			frame_bins = (bins_setting == 0) ? 1 :
				(bins_setting > MAX_BINS_DEF) ? MAX_BINS_DEF : bins_setting;
			res.frame_last = (bin_count + 1 >= frame_bins);
			bin_count = res.frame_last ? 0 : (bin_count + 1) % (1 << BIN_W);
			position = 0;
			peak_mag = '0;
			peak_index = hw;
			pans_due.push_back(res);
		end
	endfunction

	// Sender: bursts of random length separated by random gaps, some of them zero.
	int burst_left = 0;
	int gap_left = 0;

	always @(posedge clk or negedge arst_n) begin
		mag_pair_t item_out;
		if (!arst_n) begin
			mag_ch.valid <= 1'b0;
		end else if (!mag_ch.valid || mag_ch.ready) begin
			if (gap_left > 0 || positions_to_send.size() == 0) begin
				mag_ch.valid <= 1'b0;
				if (gap_left > 0)
					gap_left--;
			end else begin
				item_out = positions_to_send.pop_front();
				mag_ch.valid <= 1'b1;
				mag_ch.left_mag <= item_out.left_mag;
				mag_ch.right_mag <= item_out.right_mag;
				burst_left--;
				if (burst_left <= 0) begin
					burst_left = $urandom_range(1, 48);
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
				end
			end
		end
	end

	// Receiver: switches between always ready, light stalls, heavy stalls and a fixed beat.
	int ready_mode = 0;
	int ready_span = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pan_ch.ready <= 1'b0;
		end else begin
			if (ready_span == 0) begin
				ready_mode = $urandom_range(0, 3);
				ready_span = $urandom_range(20, 200);
			end else begin
				ready_span--;
			end
			case (ready_mode)
				0: pan_ch.ready <= 1'b1;
				1: pan_ch.ready <= ($urandom_range(0, 3) != 0);
				2: pan_ch.ready <= ($urandom_range(0, 3) == 0);
				default: pan_ch.ready <= ((ready_span % 8) < 5);
			endcase
		end
	end

	always @(posedge clk) begin
		pan_result_t want;
		if (arst_n) begin
			if (mag_ch.valid && mag_ch.ready) begin
				predict_pan(mag_pair_t'{mag_ch.left_mag, mag_ch.right_mag});
				items_accepted++;
			end
			if (pan_ch.valid && pan_ch.ready) begin
				results_checked++;
				if (pan_ch.frame_last === 1'b1)
					frames_closed++;
				if (pans_due.size() == 0) begin
					$error("unexpected pan result for bin %0d", pan_ch.bin_number);
					mismatches++;
				end else begin
					want = pans_due.pop_front();
					if (pan_ch.pan_value !== want.pan_value) begin
						$error("pan_value: expected %0d, got %0d", want.pan_value,
							pan_ch.pan_value);
						mismatches++;
					end
					if (pan_ch.pan_index !== want.pan_index) begin
						$error("pan_index: expected %0d, got %0d", want.pan_index,
							pan_ch.pan_index);
						mismatches++;
					end
					if (pan_ch.bin_number !== want.bin_number) begin
						$error("bin_number: expected %0d, got %0d", want.bin_number,
							pan_ch.bin_number);
						mismatches++;
					end
					if (pan_ch.frame_last !== want.frame_last) begin
						$error("frame_last: expected %0d, got %0d", want.frame_last,
							pan_ch.frame_last);
						mismatches++;
					end
				end
			end
		end
	end

	function automatic void queue_item(input logic [MAG_BITS_DEF-1:0] left_mag,
		input logic [MAG_BITS_DEF-1:0] right_mag);
		positions_to_send.push_back(mag_pair_t'{left_mag, right_mag});
		items_queued++;
	endfunction

	// Most bins carry one clear peak over low noise; the rest are raw noise, silence or ties.
	function automatic void queue_bin_positions(input int unsigned count);
		int                      style;
		int unsigned             peak_at;
		bit                      peak_right;
		logic [MAG_BITS_DEF-1:0] peak;
		logic [MAG_BITS_DEF-1:0] level;
		logic [MAG_BITS_DEF-1:0] left_mag;
		logic [MAG_BITS_DEF-1:0] right_mag;
		style = $urandom_range(0, 9);
		peak_at = $urandom_range(count - 1);
		peak_right = $urandom_range(0, 1);
		peak = ($urandom_range(0, 4) == 0) ? '1 : MAG_BITS_DEF'($urandom_range(1024, 65535));
		level = MAG_BITS_DEF'($urandom);
		for (int unsigned i = 0; i < count; i++) begin
			case (style)
				0, 1: begin
					left_mag = MAG_BITS_DEF'($urandom);
					right_mag = MAG_BITS_DEF'($urandom);
				end
				2: begin
					left_mag = '0;
					right_mag = '0;
				end
				3: begin
					left_mag = level;
					right_mag = level;
				end
				default: begin
					left_mag = MAG_BITS_DEF'($urandom_range(0, 1023));
					right_mag = MAG_BITS_DEF'($urandom_range(0, 1023));
					if (i == peak_at) begin
						if (peak_right)
							right_mag = peak;
						else
							left_mag = peak;
					end else if (style == 9 && i == count - 1) begin
						// A later equal peak on the other side must not win.
						if (peak_right)
							left_mag = peak;
						else
							right_mag = peak;
					end
				end
			endcase
			queue_item(left_mag, right_mag);
		end
	endfunction

	task automatic settle();
		while (items_accepted != items_queued || pans_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_register(input logic [CFG_IDX_W-1:0] which,
		input int unsigned value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= which;
		cfg_data <= value[CFG_DATA_W-1:0];
		@(posedge clk);
		cfg_we <= 1'b0;
		if (which == REG_HALF_WIDTH)
			hw_setting = value[HW_REG_W-1:0];
		else
			bins_setting = value[BINS_REG_W-1:0];
		registers_written++;
	endtask

	task automatic run_phase(input int unsigned hw_value, input int unsigned bins_value,
		input int unsigned bin_total, input int unsigned partial);
		int unsigned hw;
		settle();
		// Upper data bits are outside the half width register and must be dropped.
		write_register(REG_HALF_WIDTH, hw_value | ($urandom_range(0, 31) << HW_REG_W));
		write_register(REG_BINS_IN_FRAME, bins_value);
		hw = active_half_width();
		queue_bin_positions((position >= hw) ? 1 : hw + 1 - position);
		repeat (bin_total - 1) queue_bin_positions(hw + 1);
		if (partial != 0)
			queue_bin_positions(partial);
	endtask

	initial begin
		int          phase_no;
		int unsigned hw_value;
		int unsigned bins_value;
		int unsigned hw_eff;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_HALF_WIDTH;
		cfg_data = '0;
		mag_ch.valid = 1'b0;
		mag_ch.left_mag = '0;
		mag_ch.right_mag = '0;
		pan_ch.ready = 1'b0;
		hw_setting = HW_RESET;
		bins_setting = BINS_RESET;
		peak_mag = '0;
		peak_index = HW_RESET;
		position = 0;
		bin_count = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: silence, full-scale peaks on each side, ties and the frame wrap.
		write_register(REG_HALF_WIDTH, 2);
		write_register(REG_BINS_IN_FRAME, 3);
		queue_item(16'd0, 16'd0);
		queue_item(16'd0, 16'd0);
		queue_item(16'd0, 16'd0);
		queue_item(16'hFFFF, 16'd0);
		queue_item(16'd0, 16'd0);
		queue_item(16'd0, 16'hFFFF);
		queue_item(16'd0, 16'hFFFF);
		queue_item(16'hFFFF, 16'hFFFF);
		queue_item(16'd0, 16'd0);
		queue_item(16'd7, 16'd3);
		queue_item(16'd1000, 16'd1000);
		queue_item(16'd999, 16'd0);
		queue_item(16'd0, 16'd0);
		queue_item(16'd0, 16'd0);
		queue_item(16'd0, 16'd1);

		// Zero width and zero frame size, entered with the bin counter mid-frame.
		settle();
		write_register(REG_HALF_WIDTH, 0);
		write_register(REG_BINS_IN_FRAME, 0);
		queue_item(16'd0, 16'd0);
		queue_item(16'd0, 16'h8000);
		queue_item(16'h5555, 16'hAAAA);
		queue_item(16'd0, 16'd0);

		// Width lowered while a bin is half done.
		settle();
		write_register(REG_HALF_WIDTH, 3);
		write_register(REG_BINS_IN_FRAME, 2);
		queue_item(16'd10, 16'd20);
		queue_item(16'd30, 16'd5);
		settle();
		write_register(REG_HALF_WIDTH, 1);
		queue_item(16'd0, 16'd40);

		phase_no = 0;
		while (items_queued < ITEM_TARGET) begin
			phase_no++;
			if (phase_no == 1) begin
				// Widest bin, then a long partial bin that the next narrow width cuts short.
				run_phase(MAX_HALF_WIDTH_DEF, $urandom_range(1, 8191), 1,
					$urandom_range(150, 250));
			end else if (phase_no == 8) begin
				run_phase(MAX_HALF_WIDTH_DEF, MAX_BINS_DEF, 1, 0);
			end else begin
				case ($urandom_range(0, 9))
					0: hw_value = 0;
					1: hw_value = $urandom_range(9, 40);
					2: hw_value = 1;
					default: hw_value = $urandom_range(2, 8);
				endcase
				case ($urandom_range(0, 7))
					0: bins_value = 0;
					1: bins_value = 1;
					2: bins_value = 8191;
					3: bins_value = MAX_BINS_DEF;
					4: bins_value = $urandom_range(0, 8191);
					default: bins_value = $urandom_range(2, 6);
				endcase
				hw_eff = (hw_value == 0) ? 1 : hw_value;
				run_phase(hw_value, bins_value, $urandom_range(3, 20),
					($urandom_range(0, 2) == 0) ? $urandom_range(1, hw_eff) : 0);
			end
		end

		settle();
		$display("Run covered %0d azimuth positions in %0d phases, %0d pan results checked,",
			items_accepted, phase_no, results_checked);
		$display("%0d frame ends seen and %0d register writes.", frames_closed,
			registers_written);
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

>>> azimuth_peak_pan_estimator_top.f
rtl/core/appe_pkg.sv
rtl/core/appe_mag_if.sv
rtl/core/appe_pan_if.sv
rtl/core/appe_front.sv
rtl/core/appe_queue.sv
rtl/core/appe_back.sv
rtl/core/azimuth_peak_pan_estimator_top.sv
dv/azimuth_peak_pan_estimator_top_test.sv
